// File: design/tpd_pkg.sv
package tpd_pkg;

  localparam int BLOCK_SIDE = 16;
  localparam int SUM_BOUND_RAW = BLOCK_SIDE * BLOCK_SIDE * 255;
  localparam int SUM_BOUND = (SUM_BOUND_RAW < 65535) ? SUM_BOUND_RAW : 65535;

  localparam int PIX_W    = 8;
  localparam int MOTION_W = 22;
  localparam int LIMIT_W  = 16;
  localparam int SUM_W    = 17;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [MOTION_W-1:0] LOW_MOTION_RESET   = 22'd24;
  localparam logic [LIMIT_W-1:0]  LIMIT_NORMAL_RESET = 16'd512;
  localparam logic [LIMIT_W-1:0]  LIMIT_STRONG_RESET = 16'd768;

  localparam logic [PADDR_W-1:0] ADDR_LOW_MOTION   = 4'd0;
  localparam logic [PADDR_W-1:0] ADDR_LIMIT_NORMAL = 4'd4;
  localparam logic [PADDR_W-1:0] ADDR_LIMIT_STRONG = 4'd8;

  localparam logic [7:0] BAND_NORMAL = 8'd3;
  localparam logic [7:0] BAND_WIDE   = 8'd4;
  localparam logic [7:0] DIFF_SMALL  = 8'd7;
  localparam logic [7:0] DIFF_MID    = 8'd15;
  localparam logic [3:0] STEP_SMALL  = 4'd3;
  localparam logic [3:0] STEP_MID    = 4'd4;
  localparam logic [3:0] STEP_LARGE  = 4'd6;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W + 1)'(SUM_BOUND);
  localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W + 1)'(SUM_BOUND);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [MOTION_W-1:0] motion_t;
  typedef logic [LIMIT_W-1:0] limit_t;
  typedef logic signed [SUM_W-1:0] sum_t;

endpackage

// File: design/tpd_if.sv
interface tpd_in_if import tpd_pkg::*; ();
  logic    valid;
  logic    ready;
  pix_t    avg_pixel;
  pix_t    raw_pixel;
  motion_t motion_sq;
  logic    strong_mode;
  logic    last_pixel;

  modport source (
    output valid, avg_pixel, raw_pixel, motion_sq, strong_mode, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, avg_pixel, raw_pixel, motion_sq, strong_mode, last_pixel,
    output ready
  );
endinterface

interface tpd_out_if import tpd_pkg::*; ();
  logic valid;
  logic ready;
  pix_t filtered_pixel;
  logic block_done;
  logic use_filtered;
  sum_t block_sum;

  modport source (
    output valid, filtered_pixel, block_done, use_filtered, block_sum,
    input  ready
  );
  modport sink (
    input  valid, filtered_pixel, block_done, use_filtered, block_sum,
    output ready
  );
endinterface

// File: design/temporal_pixel_denoise_block.sv
// channel   | dir | handshake           | payload
// pix_in    | in  | valid/ready         | avg_pixel, raw_pixel, motion_sq,
//           |     |                     | strong_mode, last_pixel
// pix_out   | out | valid/ready         | filtered_pixel, block_done, use_filtered,
//           |     |                     | block_sum
// apb       | in  | psel/penable/pready | paddr, pwdata, prdata
//
// one item per cycle sustained while pix_out.ready is high; an item passes the input register, then the result register
// block state (running sum, motion and strong flags) updates as an item enters
// the result register, so consecutive pixels chain without gaps
// rst is synchronous: clears both stages, block state and the registers to defaults
// pix_out.ready low holds the result; pix_in keeps accepting until both stages hold items
module temporal_pixel_denoise_block import tpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  tpd_in_if.sink             pix_in,
  tpd_out_if.source          pix_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // configuration
  motion_t low_motion_threshold;
  limit_t  sum_limit_normal;
  limit_t  sum_limit_strong;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_motion_threshold <= LOW_MOTION_RESET;
      sum_limit_normal     <= LIMIT_NORMAL_RESET;
      sum_limit_strong     <= LIMIT_STRONG_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        ADDR_LOW_MOTION:   low_motion_threshold <= pwdata[MOTION_W-1:0];
        ADDR_LIMIT_NORMAL: sum_limit_normal     <= pwdata[LIMIT_W-1:0];
        ADDR_LIMIT_STRONG: sum_limit_strong     <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_LOW_MOTION:   prdata = PDATA_W'(low_motion_threshold);
      ADDR_LIMIT_NORMAL: prdata = PDATA_W'(sum_limit_normal);
      ADDR_LIMIT_STRONG: prdata = PDATA_W'(sum_limit_strong);
      default:           prdata = '0;
    endcase
  end

  // input register
  logic    s1_valid;
  pix_t    s1_avg;
  pix_t    s1_raw;
  motion_t s1_motion;
  logic    s1_strong;
  logic    s1_last;

  // block state
  sum_t change_sum;
  logic low_motion_flag;
  logic strong_flag;
  logic mid_block;

  logic advance;
  assign advance      = s1_valid && (!pix_out.valid || pix_out.ready);
  assign pix_in.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_in.ready) begin
      s1_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_in.ready && pix_in.valid) begin
      s1_avg    <= pix_in.avg_pixel;
      s1_raw    <= pix_in.raw_pixel;
      s1_motion <= pix_in.motion_sq;
      s1_strong <= pix_in.strong_mode;
      s1_last   <= pix_in.last_pixel;
    end
  end

  // per pixel filter
  logic                  lm_eff;
  logic                  st_eff;
  sum_t                  sum_base;
  logic [7:0]            band;
  logic [3:0]            step;
  logic signed [PIX_W:0] diff;
  logic [PIX_W-1:0]      absdiff;
  logic [PIX_W:0]        pix_up;
  logic [PIX_W:0]        pix_dn;
  pix_t                  pix_next;
  logic signed [SUM_W:0] delta;
  logic signed [SUM_W:0] sum_raw;
  sum_t                  sum_next;
  logic [SUM_W-1:0]      sum_mag;
  limit_t                limit;
  logic                  use_next;

  always_comb begin
    lm_eff   = mid_block ? low_motion_flag : (s1_motion <= low_motion_threshold);
    st_eff   = mid_block ? strong_flag : s1_strong;
    sum_base = mid_block ? change_sum : '0;

    band = (lm_eff && st_eff) ? BAND_WIDE : BAND_NORMAL;
    diff = $signed({1'b0, s1_avg}) - $signed({1'b0, s1_raw});
    absdiff = diff[PIX_W] ? PIX_W'(-diff) : diff[PIX_W-1:0];

    if (absdiff <= DIFF_SMALL) begin
      step = STEP_SMALL;
    end else if (absdiff <= DIFF_MID) begin
      step = STEP_MID;
    end else begin
      step = STEP_LARGE;
    end
    if (lm_eff) begin
      step = step + (st_eff ? 4'd2 : 4'd1);
    end

    pix_up = {1'b0, s1_raw} + (PIX_W + 1)'(step);
    pix_dn = {1'b0, s1_raw} - (PIX_W + 1)'(step);

    if (absdiff <= band) begin
      pix_next = s1_avg;
      delta    = (SUM_W + 1)'(diff);
    end else if (!diff[PIX_W]) begin
      pix_next = pix_up[PIX_W] ? PIX_MAX : pix_up[PIX_W-1:0];
      delta    = $signed({{(SUM_W - 3){1'b0}}, step});
    end else begin
      pix_next = pix_dn[PIX_W] ? '0 : pix_dn[PIX_W-1:0];
      delta    = -$signed({{(SUM_W - 3){1'b0}}, step});
    end

    sum_raw = (SUM_W + 1)'(sum_base) + delta;
    if (sum_raw > SUM_MAX) begin
      sum_next = SUM_W'(SUM_MAX);
    end else if (sum_raw < SUM_MIN) begin
      sum_next = SUM_W'(SUM_MIN);
    end else begin
      sum_next = sum_raw[SUM_W-1:0];
    end

    sum_mag  = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : sum_next;
    limit    = st_eff ? sum_limit_strong : sum_limit_normal;
    use_next = s1_last && (sum_mag <= {1'b0, limit});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      change_sum      <= '0;
      low_motion_flag <= 1'b0;
      strong_flag     <= 1'b0;
      mid_block       <= 1'b0;
    end else if (advance) begin
      change_sum      <= sum_next;
      low_motion_flag <= lm_eff;
      strong_flag     <= st_eff;
      mid_block       <= !s1_last;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (!pix_out.valid || pix_out.ready) begin
      pix_out.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pix_out.filtered_pixel <= pix_next;
      pix_out.block_done     <= s1_last;
      pix_out.use_filtered   <= use_next;
      pix_out.block_sum      <= sum_next;
    end
  end

endmodule

// File: design/tpd_checker.sv
module tpd_checker import tpd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input pix_t filtered_pixel,
  input logic block_done,
  input logic use_filtered,
  input sum_t block_sum
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_pixel)
      && $stable(block_done) && $stable(use_filtered) && $stable(block_sum))
    else $error("result changed while stalled");

  // keep decision only on the last pixel
  a_use_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !block_done |-> !use_filtered)
    else $error("use_filtered without block_done");

  // running sum stays saturated
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(block_sum) <= $signed(SUM_MAX))
      && ($signed(block_sum) >= $signed(SUM_MIN)))
    else $error("block_sum outside bound");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // an item accepted into an empty block pipe passes the input register and the result register to the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("accepted item did not reach the output");

endmodule

bind temporal_pixel_denoise_block tpd_checker u_tpd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (pix_in.valid),
  .in_ready       (pix_in.ready),
  .out_valid      (pix_out.valid),
  .out_ready      (pix_out.ready),
  .filtered_pixel (pix_out.filtered_pixel),
  .block_done     (pix_out.block_done),
  .use_filtered   (pix_out.use_filtered),
  .block_sum      (pix_out.block_sum)
);
